### rtl/mmr_pkg.sv
// Package for the min-max rescaling block: widths, register indexes,
// transaction payload types and the divider status type.
// Depends on nothing; every other file in rtl/ uses it.
package mmr_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int OUT_WIDTH    = 24;

    // The dividend is |out_high - out_low| times (x - min).
    localparam int PROD_WIDTH = OUT_WIDTH + SAMPLE_WIDTH;
    localparam int CNT_WIDTH  = $clog2(OUT_WIDTH + 1);

    localparam int CFG_IDX_WIDTH = 2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_OUT_LOW  = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_OUT_HIGH = 2'd1;

    localparam logic [OUT_WIDTH-1:0] OUT_LOW_RESET  = 24'h000000;
    localparam logic [OUT_WIDTH-1:0] OUT_HIGH_RESET = 24'h7FFFFF;

    localparam logic MODE_SCAN  = 1'b0;
    localparam logic MODE_APPLY = 1'b1;

    typedef struct packed {
        logic                            mode;
        logic signed [SAMPLE_WIDTH-1:0]  sample;
        logic                            first;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] scaled;
        logic                        clamped;
        logic                        flat;
    } out_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### rtl/mmr_div.sv
// Radix-2 restoring divider producing one quotient bit per cycle.
// Depends on mmr_pkg for widths and the status struct.
module mmr_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [mmr_pkg::PROD_WIDTH-1:0]      dividend,
    input  logic [mmr_pkg::SAMPLE_WIDTH-1:0]    divisor,
    output logic [mmr_pkg::OUT_WIDTH-1:0]       quot,
    output logic                                rem_nz,
    output mmr_pkg::div_stat_t                  stat
);

    localparam int SW = mmr_pkg::SAMPLE_WIDTH;
    localparam int OW = mmr_pkg::OUT_WIDTH;
    localparam int PW = mmr_pkg::PROD_WIDTH;
    localparam int CW = mmr_pkg::CNT_WIDTH;

    logic [SW-1:0] rem_reg, rem_next;
    logic [OW-1:0] quo_reg, quo_next;
    logic [SW-1:0] den_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;

    logic [SW:0]   trial;
    logic [SW:0]   diff;

    // The quotient is known to fit in OW bits, so the upper dividend bits
    // start out below the divisor and only OW steps are needed.
    always_comb
    begin
        trial     = {rem_reg, quo_reg[OW-1]};
        diff      = trial - {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = dividend[PW-1:OW];
            quo_next = dividend[OW-1:0];
            cnt_next = CW'(OW);
        end
        else if (cnt_reg != '0)
        begin
            if (!diff[SW])
            begin
                rem_next = diff[SW-1:0];
                quo_next = {quo_reg[OW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[SW-1:0];
                quo_next = {quo_reg[OW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= divisor;
        end
    end

    assign quot      = quo_reg;
    assign rem_nz    = (rem_reg != '0);
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule

### rtl/min_max_rescale.sv
// Top level of the min-max rescaling block: handshakes, configuration,
// running extremes, sequencer and the multiply ahead of the divider.
// Depends on mmr_pkg and mmr_div.
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+----------------------------
//  in      | to block  | in_valid / in_ready   | in_data  (mode,sample,first)
//  out     | from blk  | out_valid / out_ready | out_data (scaled,clamped,flat)
//  cfg     | to block  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// After a scan transaction the block is ready again at once.
// An apply transaction passes through these steps before its result is loaded:
// the multiply, the load of the divider, the radix-2 division, a state that
// sees the divider finish and the load of the result, which waits while an
// earlier result is stalled. The next sample is taken at the edge after the
// result is loaded. A zero scanned range skips the multiply and divide and
// goes straight to the state that loads its result.
// Reset clears the running extremes to zero and the range to [0..8388607].
// A result held by a stalled consumer does not stop the next input; only a
// second result that would overwrite it waits.
module min_max_rescale (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  mmr_pkg::in_item_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output mmr_pkg::out_item_t                   out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mmr_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
    input  logic [mmr_pkg::OUT_WIDTH-1:0]        cfg_data
);

    localparam int SW = mmr_pkg::SAMPLE_WIDTH;
    localparam int OW = mmr_pkg::OUT_WIDTH;
    localparam int PW = mmr_pkg::PROD_WIDTH;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] state_reg, state_next;

    // Configuration registers, always writable.
    logic signed [OW-1:0] out_low_reg, out_high_reg;

    // Running extremes of the scan pass.
    logic signed [SW-1:0] min_reg, max_reg;

    // Per-transaction working registers.
    logic [SW-1:0]   d_reg;
    logic [SW-1:0]   den_reg;
    logic [OW-1:0]   mag_reg;
    logic            neg_reg;
    logic            clamped_reg;
    logic            flat_reg;
    logic [PW-1:0]   prod_reg;
    logic            start_reg, start_next;

    logic            out_valid_reg, out_valid_next;
    mmr_pkg::out_item_t out_data_reg;

    logic                 accept;
    logic                 load_out;
    logic signed [SW-1:0] x_s;
    logic                 below, above;
    logic signed [SW-1:0] xc;
    logic [SW:0]          d_full, den_full;
    logic [OW:0]          span_full, span_abs;
    logic                 flat_now;

    logic [OW-1:0]        quot;
    logic                 rem_nz;
    mmr_pkg::div_stat_t   div_stat;
    logic [OW:0]          res_full;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Clamp the sample into the scanned range and form the differences.
    assign x_s      = in_data.sample;
    assign below    = (x_s < min_reg);
    assign above    = (x_s > max_reg);
    assign xc       = below ? min_reg : (above ? max_reg : x_s);
    assign d_full   = {xc[SW-1], xc} - {min_reg[SW-1], min_reg};
    assign den_full = {max_reg[SW-1], max_reg} - {min_reg[SW-1], min_reg};
    assign flat_now = (max_reg <= min_reg);

    // The target span may be negative; the divider works on its magnitude.
    assign span_full = {out_high_reg[OW-1], out_high_reg} - {out_low_reg[OW-1], out_low_reg};
    assign span_abs  = span_full[OW] ? (~span_full + 1'b1) : span_full;

    // A negative span needs the floor toward minus infinity, which is the
    // negated quotient minus one whenever the remainder is not zero.
    always_comb
    begin
        if (neg_reg)
        begin
            res_full = {out_low_reg[OW-1], out_low_reg} - {1'b0, quot}
                       - {{OW{1'b0}}, rem_nz};
        end
        else
        begin
            res_full = {out_low_reg[OW-1], out_low_reg} + {1'b0, quot};
        end
    end

    assign load_out = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        start_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (in_data.mode == mmr_pkg::MODE_APPLY))
                begin
                    state_next = flat_now ? S_FIN : S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
                start_next = 1'b1;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_low_reg   <= mmr_pkg::OUT_LOW_RESET;
            out_high_reg  <= mmr_pkg::OUT_HIGH_RESET;
            min_reg       <= '0;
            max_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == mmr_pkg::CFG_OUT_LOW)
                begin
                    out_low_reg <= cfg_data;
                end
                else if (cfg_index == mmr_pkg::CFG_OUT_HIGH)
                begin
                    out_high_reg <= cfg_data;
                end
            end
            if (accept && (in_data.mode == mmr_pkg::MODE_SCAN))
            begin
                if (in_data.first)
                begin
                    min_reg <= x_s;
                    max_reg <= x_s;
                end
                else
                begin
                    if (below)
                    begin
                        min_reg <= x_s;
                    end
                    if (above)
                    begin
                        max_reg <= x_s;
                    end
                end
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            d_reg       <= d_full[SW-1:0];
            den_reg     <= den_full[SW-1:0];
            mag_reg     <= span_abs[OW-1:0];
            neg_reg     <= span_full[OW];
            clamped_reg <= below || above;
            flat_reg    <= flat_now;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= PW'(mag_reg) * PW'(d_reg);
        end
        if (load_out)
        begin
            out_data_reg.scaled  <= flat_reg ? out_low_reg : res_full[OW-1:0];
            out_data_reg.clamped <= clamped_reg;
            out_data_reg.flat    <= flat_reg;
        end
    end

    mmr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .quot     (quot),
        .rem_nz   (rem_nz),
        .stat     (div_stat)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### rtl/mmr_chk.sv
// Port-level checker for the min-max rescaling block, bound to its top level.
// Depends on mmr_pkg and on the port list of min_max_rescale.
module mmr_chk (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  mmr_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  mmr_pkg::out_item_t out_data
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // An apply transaction occupies the block for at least the next cycle.
    a_apply_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.mode == mmr_pkg::MODE_APPLY) |=> !in_ready)
        else $error("block ready right after an apply transaction");

    // A scan transaction leaves the block ready for the next sample.
    a_scan_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.mode == mmr_pkg::MODE_SCAN) |=> in_ready)
        else $error("scan transaction stalled the input");

    // A new result appears only after the block has been busy.
    a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without an apply in progress");

endmodule

bind min_max_rescale mmr_chk u_mmr_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

### tb/tb_min_max_rescale.sv
// Testbench for min_max_rescale: scan and apply transactions with random pacing,
// target range rewritten between phases, results checked against a local predictor.
// Depends on mmr_pkg and the min_max_rescale RTL.
module tb_min_max_rescale;

    localparam int SW = mmr_pkg::SAMPLE_WIDTH;
    localparam int OW = mmr_pkg::OUT_WIDTH;
    localparam int IW = mmr_pkg::CFG_IDX_WIDTH;

    // Sample and range extremes of the signed 24-bit fields.
    localparam int SMIN = -8388608;
    localparam int SMAX = 8388607;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 175;
    // Settling time; it outlasts the longest apply transaction with some margin.
    localparam int SETTLE_CYCLES   = 40;
    // Cycles without any accepted transaction before the run is declared hung.
    localparam int STALL_LIMIT     = 2000;

    // Indexes past the two real registers; writes to them must be ignored.
    localparam logic [IW-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [IW-1:0] CFG_SPARE_B = 2'd3;

    // One row of the directed table. Where typed is set, res holds the result
    // read straight off the arithmetic; otherwise the predictor supplies it.
    typedef struct {
        mmr_pkg::in_item_t  item;
        bit                 typed;
        mmr_pkg::out_item_t res;
    } step_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    mmr_pkg::in_item_t   in_data;
    logic                out_valid;
    logic                out_ready;
    mmr_pkg::out_item_t  out_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [IW-1:0]       cfg_index;
    logic [OW-1:0]       cfg_data;

    // Predictor state: scanned extremes and the target range.
    logic signed [SW-1:0] seen_min;
    logic signed [SW-1:0] seen_max;
    logic signed [OW-1:0] tgt_low;
    logic signed [OW-1:0] tgt_high;

    // Rescaled results still owed by the block, oldest first.
    mmr_pkg::out_item_t scaled_q[$];
    mmr_pkg::out_item_t want;
    step_row_t directed_plan[$];

    int  err_count;
    int  items_sent;
    int  results_seen;
    int  idle_cycles;
    // While set, neither side inserts idle cycles.
    bit  steady;

    min_max_rescale u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor. A scan transaction only moves the extremes and returns 0.
    // An apply transaction clamps the sample into the scanned range, then maps
    // it with a floor division toward minus infinity, which keeps the result
    // between the two ends of the target range even when the range is inverted.
    function automatic bit rescale_sample(input mmr_pkg::in_item_t it,
                                          output mmr_pkg::out_item_t res);
        longint x;
        longint lo;
        longint hi;
        longint num;
        longint quo;
        x   = longint'($signed(it.sample));
        lo  = longint'(seen_min);
        hi  = longint'(seen_max);
        res = '0;
        if (it.mode == mmr_pkg::MODE_SCAN)
        begin
            if (it.first)
            begin
                seen_min = it.sample;
                seen_max = it.sample;
            end
            else
            begin
                if (x < lo)
                    seen_min = it.sample;
                if (x > hi)
                    seen_max = it.sample;
            end
            return 1'b0;
        end
        if (x < lo)
        begin
            x           = lo;
            res.clamped = 1'b1;
        end
        else if (x > hi)
        begin
            x           = hi;
            res.clamped = 1'b1;
        end
        // A scanned range of zero width maps everything onto the low end.
        if (hi <= lo)
        begin
            res.flat   = 1'b1;
            res.scaled = tgt_low;
        end
        else
        begin
            num = (longint'(tgt_high) - longint'(tgt_low)) * (x - lo);
            quo = num / (hi - lo);
            if ((num % (hi - lo)) != 0 && num < 0)
                quo = quo - 1;
            quo        = quo + longint'(tgt_low);
            res.scaled = quo[OW-1:0];
        end
        return 1'b1;
    endfunction

    function automatic void add_row(input logic mode, input int value, input logic first,
                                    input bit typed, input int scaled,
                                    input logic clamped, input logic flat);
        step_row_t row;
        row.item.mode   = mode;
        row.item.sample = value[SW-1:0];
        row.item.first  = first;
        row.typed       = typed;
        row.res.scaled  = scaled[OW-1:0];
        row.res.clamped = clamped;
        row.res.flat    = flat;
        directed_plan.push_back(row);
    endfunction

    // Mostly back to back, sometimes a few cycles, now and then a long pause.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SW-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return SW'(SMIN);
            1:       return SW'(SMAX);
            2:       return '0;
            3, 4, 5: return SW'(int'($urandom_range(0, 64)) - 32);
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic logic [SW-1:0] pick_between(input longint lo,
                                                   input longint hi);
        longint v;
        v = lo + longint'($urandom_range(0, 32'(hi - lo)));
        return SW'(v);
    endfunction

    // Present one sample transaction and hold it until the block takes it. The
    // expectation is queued at the accepting edge, so the predictor always sees
    // the extremes left by every earlier transaction.
    task automatic send_item(input mmr_pkg::in_item_t it, input bit typed,
                             input mmr_pkg::out_item_t typed_res);
        int unsigned        gap;
        mmr_pkg::out_item_t res;
        gap = idle_len();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (rescale_sample(it, res))
            scaled_q.push_back(typed ? typed_res : res);
        items_sent++;
    endtask

    // Apply transactions, most of them inside the range scanned so far.
    task automatic apply_burst(input int count);
        mmr_pkg::in_item_t it;
        for (int k = 0; k < count; k++)
        begin
            it.mode  = mmr_pkg::MODE_APPLY;
            it.first = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 80)
                it.sample = pick_between(longint'(seen_min), longint'(seen_max));
            else
                it.sample = pick_value();
            send_item(it, 1'b0, '0);
        end
    endtask

    // Stop sending, wait for every owed result, then let the pipeline settle.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (scaled_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IW-1:0] idx,
                             input logic [OW-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == mmr_pkg::CFG_OUT_LOW)
            tgt_low = val;
        else if (idx == mmr_pkg::CFG_OUT_HIGH)
            tgt_high = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: the consumer alternates ready runs with stalls of random
    // length, again mostly short with an occasional long one.
    initial
    begin
        int unsigned run_left;
        int unsigned r;
        out_ready = 1'b0;
        run_left  = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (steady)
                out_ready <= 1'b1;
            else if (run_left > 0)
                run_left--;
            else if (out_ready)
            begin
                r         = $urandom_range(0, 99);
                out_ready <= 1'b0;
                if (r < 70)
                    run_left = $urandom_range(0, 2);
                else if (r < 92)
                    run_left = $urandom_range(3, 8);
                else
                    run_left = $urandom_range(15, 40);
            end
            else
            begin
                out_ready <= 1'b1;
                run_left  = $urandom_range(0, 12);
            end
        end
    end

    // Every accepted result is compared with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (scaled_q.size() == 0)
            begin
                $error("result transaction with nothing expected: scaled=%0d clamped=%0b flat=%0b",
                       $signed(out_data.scaled), out_data.clamped, out_data.flat);
                err_count++;
            end
            else
            begin
                want = scaled_q.pop_front();
                if (out_data.scaled !== want.scaled)
                begin
                    $error("scaled: expected %0d, got %0d",
                           $signed(want.scaled), $signed(out_data.scaled));
                    err_count++;
                end
                if (out_data.clamped !== want.clamped)
                begin
                    $error("clamped: expected %0b, got %0b", want.clamped, out_data.clamped);
                    err_count++;
                end
                if (out_data.flat !== want.flat)
                begin
                    $error("flat: expected %0b, got %0b", want.flat, out_data.flat);
                    err_count++;
                end
            end
        end
    end

    // Hang detection: any accepted transaction on any channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles, %0d results owed",
                     STALL_LIMIT, scaled_q.size());
            $display("FAIL min_max_rescale");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int                 range_lows[PHASES];
        int                 range_highs[PHASES];
        int                 ph_start;
        int                 directed_count;
        int                 kind;
        int                 n_scan;
        longint             a;
        longint             b;
        mmr_pkg::in_item_t  it;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = mmr_pkg::CFG_OUT_LOW;
        cfg_data     = '0;
        steady       = 1'b0;
        err_count    = 0;
        items_sent   = 0;
        results_seen = 0;
        idle_cycles  = 0;
        seen_min     = '0;
        seen_max     = '0;
        tgt_low      = mmr_pkg::OUT_LOW_RESET;
        tgt_high     = mmr_pkg::OUT_HIGH_RESET;

        // Target ranges per phase: full span, inverted full span, zero width at
        // either end, the reset range, small ranges both ways, and one random.
        range_lows  = '{SMIN, SMAX, SMIN, SMAX, 0, -1000, 0, 300};
        range_highs = '{SMAX, SMIN, SMIN, SMAX, SMAX, 1000, 0, -700};
        range_lows[6]  = int'($signed(OW'($urandom)));
        range_highs[6] = int'($signed(OW'($urandom)));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, run with the reset range [0..SMAX]. Before any scan
        // the extremes are both zero, so every apply is flat; any nonzero
        // sample is also clamped, and the first flag does nothing in apply mode.
        add_row(mmr_pkg::MODE_APPLY, 0,        1'b0, 1'b1, 0,    1'b0, 1'b1);
        add_row(mmr_pkg::MODE_APPLY, 1234,     1'b1, 1'b1, 0,    1'b1, 1'b1);
        add_row(mmr_pkg::MODE_APPLY, SMIN,     1'b0, 1'b1, 0,    1'b1, 1'b1);
        // A single scanned sample leaves a zero-width range.
        add_row(mmr_pkg::MODE_SCAN,  100,      1'b1, 1'b0, 0,    1'b0, 1'b0);
        add_row(mmr_pkg::MODE_APPLY, 100,      1'b0, 1'b1, 0,    1'b0, 1'b1);
        add_row(mmr_pkg::MODE_APPLY, 99,       1'b0, 1'b1, 0,    1'b1, 1'b1);
        // Widen to the full sample range; the ends map onto the range ends.
        add_row(mmr_pkg::MODE_SCAN,  SMIN,     1'b0, 1'b0, 0,    1'b0, 1'b0);
        add_row(mmr_pkg::MODE_SCAN,  SMAX,     1'b0, 1'b0, 0,    1'b0, 1'b0);
        add_row(mmr_pkg::MODE_SCAN,  5,        1'b0, 1'b0, 0,    1'b0, 1'b0);
        add_row(mmr_pkg::MODE_APPLY, SMIN,     1'b1, 1'b1, 0,    1'b0, 1'b0);
        add_row(mmr_pkg::MODE_APPLY, SMAX,     1'b0, 1'b1, SMAX, 1'b0, 1'b0);
        add_row(mmr_pkg::MODE_APPLY, 0,        1'b0, 1'b0, 0,    1'b0, 1'b0);
        add_row(mmr_pkg::MODE_APPLY, -1,       1'b0, 1'b0, 0,    1'b0, 1'b0);
        add_row(mmr_pkg::MODE_APPLY, 'h555555, 1'b0, 1'b0, 0,    1'b0, 1'b0);
        add_row(mmr_pkg::MODE_APPLY, -5592406, 1'b1, 1'b0, 0,    1'b0, 1'b0);
        // Restart from a narrow range; samples outside it clamp to the ends.
        add_row(mmr_pkg::MODE_SCAN,  7,        1'b1, 1'b0, 0,    1'b0, 1'b0);
        add_row(mmr_pkg::MODE_SCAN,  9,        1'b0, 1'b0, 0,    1'b0, 1'b0);
        add_row(mmr_pkg::MODE_SCAN,  8,        1'b0, 1'b0, 0,    1'b0, 1'b0);
        add_row(mmr_pkg::MODE_APPLY, 6,        1'b0, 1'b1, 0,    1'b1, 1'b0);
        add_row(mmr_pkg::MODE_APPLY, 10,       1'b0, 1'b1, SMAX, 1'b1, 1'b0);
        add_row(mmr_pkg::MODE_APPLY, 8,        1'b0, 1'b0, 0,    1'b0, 1'b0);
        add_row(mmr_pkg::MODE_SCAN,  -3,       1'b1, 1'b0, 0,    1'b0, 1'b0);
        add_row(mmr_pkg::MODE_APPLY, -3,       1'b0, 1'b1, 0,    1'b0, 1'b1);

        foreach (directed_plan[i])
            send_item(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].res);
        directed_count = items_sent;

        // Random part. Each phase starts from an idle block: the sender waits
        // for every owed result, then the range registers are rewritten.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            steady = (ph == 2 || ph == 5);
            if (ph == 3 || ph == 6)
                write_reg(CFG_SPARE_A, OW'($urandom));
            if ($urandom_range(0, 1))
            begin
                write_reg(mmr_pkg::CFG_OUT_LOW,  OW'(range_lows[ph]));
                write_reg(mmr_pkg::CFG_OUT_HIGH, OW'(range_highs[ph]));
            end
            else
            begin
                write_reg(mmr_pkg::CFG_OUT_HIGH, OW'(range_highs[ph]));
                write_reg(mmr_pkg::CFG_OUT_LOW,  OW'(range_lows[ph]));
            end
            if (ph == 3 || ph == 6)
                write_reg(CFG_SPARE_B, OW'($urandom));

            ph_start = items_sent;
            while (items_sent < ph_start + ITEMS_PER_PHASE)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 7)
                begin
                    // Well-formed data set: a restarting scan pass, then applies.
                    a = longint'($signed(pick_value()));
                    if ($urandom_range(0, 1))
                        b = a + longint'($urandom_range(0, 20));
                    else
                        b = longint'($signed(pick_value()));
                    if (b > SMAX)
                        b = SMAX;
                    n_scan = $urandom_range(1, 6);
                    for (int k = 0; k < n_scan; k++)
                    begin
                        it.mode  = mmr_pkg::MODE_SCAN;
                        it.first = (k == 0);
                        if (k == 0)
                            it.sample = SW'(a);
                        else if (k == 1)
                            it.sample = SW'(b);
                        else if (a < b)
                            it.sample = pick_between(a, b);
                        else
                            it.sample = pick_between(b, a);
                        send_item(it, 1'b0, '0);
                    end
                    apply_burst($urandom_range(1, 8));
                end
                else if (kind == 7)
                begin
                    // Noise: every field random.
                    it.mode   = 1'($urandom_range(0, 1));
                    it.sample = pick_value();
                    it.first  = 1'($urandom_range(0, 1));
                    send_item(it, 1'b0, '0);
                end
                else if (kind == 8)
                begin
                    // Broken set: scans that extend the old range without a restart.
                    n_scan = $urandom_range(1, 3);
                    for (int k = 0; k < n_scan; k++)
                    begin
                        it.mode   = mmr_pkg::MODE_SCAN;
                        it.first  = 1'b0;
                        it.sample = pick_value();
                        send_item(it, 1'b0, '0);
                    end
                    apply_burst($urandom_range(1, 3));
                end
                else
                    apply_burst($urandom_range(1, 4));
            end
        end

        steady = 1'b0;
        drain();
        $display("Covered %0d sample transactions (%0d directed) and %0d results",
                 items_sent, directed_count, results_seen);
        $display("over %0d target ranges, inverted and zero-width ones included.", PHASES + 1);
        if (err_count == 0 && scaled_q.size() == 0)
            $display("PASS min_max_rescale");
        else
            $display("FAIL min_max_rescale");
        $finish;
    end

endmodule
